// ===== hw/rtl/sha1_hash_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// sha1 hash engine assertion macros
// shared property forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_ENGINE_TOP_ASSERT_SVH
`define SHA1_HASH_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define SHA1HE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA1HE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sha1he_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1he_pkg
// types, codes and constants shared by the sha1 hash engine modules
// ----------------------------------------------------------------------------
package sha1he_pkg;

  localparam int unsigned NUM_CHAIN  = 5;
  localparam int unsigned NUM_SCHED  = 16;
  localparam int unsigned NUM_ROUNDS = 80;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd55;
  localparam logic [5:0] END_POS  = 6'd63;
  localparam logic [2:0] LAST_IDX = 3'd4;

  localparam logic [31:0] IV_WORDS [NUM_CHAIN] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_WORDS [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_WINIT,
    ST_ROUND,
    ST_CADD
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_WINIT,
    OP_ROUND,
    OP_CADD,
    OP_FINAL
  } op_t;

  typedef enum logic [1:0] {
    BSEL_IN,
    BSEL_PAD80,
    BSEL_ZERO,
    BSEL_LEN
  } bsel_t;

  typedef struct packed {
    op_t   op;
    bsel_t bsel;
    logic  count;
  } cmd_t;

  typedef struct packed {
    logic pos_end;
    logic pos_len;
    logic rnd_last;
    logic out_busy;
  } stat_t;

endpackage

// ===== hw/rtl/sha1he_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1he_ctrl
// sequencer: byte intake, padding, length, compression and digest hand-off
// ----------------------------------------------------------------------------
module sha1he_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_byte_valid,
  input  logic               in_last_item,
  output logic               in_stall,
  input  sha1he_pkg::stat_t  stat,
  output sha1he_pkg::cmd_t   cmd
);

  sha1he_pkg::state_t state_r, state_nxt;
  logic last_pend_r, last_pend_nxt;
  logic pad_first_r, pad_first_nxt;
  logic final_r, final_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1he_pkg::ST_IDLE;
      last_pend_r <= 1'b0;
      pad_first_r <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_pend_r <= last_pend_nxt;
      pad_first_r <= pad_first_nxt;
      final_r     <= final_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    last_pend_nxt = last_pend_r;
    pad_first_nxt = pad_first_r;
    final_nxt     = final_r;
    unique case (state_r)
      sha1he_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid && stat.pos_end) begin
            state_nxt     = sha1he_pkg::ST_WINIT;
            last_pend_nxt = in_last_item;
            pad_first_nxt = 1'b1;
          end else if (in_last_item) begin
            state_nxt     = sha1he_pkg::ST_PAD;
            last_pend_nxt = 1'b1;
            pad_first_nxt = 1'b1;
          end
        end
      end
      sha1he_pkg::ST_PAD: begin
        pad_first_nxt = 1'b0;
        if (stat.pos_end) begin
          state_nxt = sha1he_pkg::ST_WINIT;
        end else if (stat.pos_len) begin
          state_nxt = sha1he_pkg::ST_LEN;
        end
      end
      sha1he_pkg::ST_LEN: begin
        if (stat.pos_end) begin
          state_nxt = sha1he_pkg::ST_WINIT;
          final_nxt = 1'b1;
        end
      end
      sha1he_pkg::ST_WINIT: begin
        state_nxt = sha1he_pkg::ST_ROUND;
      end
      sha1he_pkg::ST_ROUND: begin
        if (stat.rnd_last) begin
          state_nxt = sha1he_pkg::ST_CADD;
        end
      end
      sha1he_pkg::ST_CADD: begin
        if (final_r) begin
          if (!stat.out_busy) begin
            state_nxt     = sha1he_pkg::ST_IDLE;
            final_nxt     = 1'b0;
            last_pend_nxt = 1'b0;
          end
        end else if (last_pend_r) begin
          state_nxt = sha1he_pkg::ST_PAD;
        end else begin
          state_nxt = sha1he_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sha1he_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = 1'b1;
    cmd.op    = sha1he_pkg::OP_NONE;
    cmd.bsel  = sha1he_pkg::BSEL_IN;
    cmd.count = 1'b0;
    unique case (state_r)
      sha1he_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_byte_valid) begin
          cmd.op    = sha1he_pkg::OP_INSERT;
          cmd.count = 1'b1;
        end
      end
      sha1he_pkg::ST_PAD: begin
        cmd.op   = sha1he_pkg::OP_INSERT;
        cmd.bsel = pad_first_r ? sha1he_pkg::BSEL_PAD80 : sha1he_pkg::BSEL_ZERO;
      end
      sha1he_pkg::ST_LEN: begin
        cmd.op   = sha1he_pkg::OP_INSERT;
        cmd.bsel = sha1he_pkg::BSEL_LEN;
      end
      sha1he_pkg::ST_WINIT: begin
        cmd.op = sha1he_pkg::OP_WINIT;
      end
      sha1he_pkg::ST_ROUND: begin
        cmd.op = sha1he_pkg::OP_ROUND;
      end
      sha1he_pkg::ST_CADD: begin
        if (!final_r) begin
          cmd.op = sha1he_pkg::OP_CADD;
        end else if (!stat.out_busy) begin
          cmd.op = sha1he_pkg::OP_FINAL;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sha1he_dpath.sv =====
// ----------------------------------------------------------------------------
// sha1he_dpath
// byte packing, message schedule line, round unit, chaining and digest buffer
// ----------------------------------------------------------------------------
module sha1he_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  sha1he_pkg::cmd_t   cmd,
  output sha1he_pkg::stat_t  stat,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);

  localparam int unsigned NC = sha1he_pkg::NUM_CHAIN;
  localparam int unsigned NS = sha1he_pkg::NUM_SCHED;

  logic [31:0] chain_r [NC];
  logic [31:0] wk_r    [NC];
  logic [31:0] dig_r   [NC];
  logic [31:0] line_r  [NS];
  logic [23:0] acc_r;
  logic [5:0]  pos_r;
  logic [63:0] bits_r;
  logic [6:0]  rnd_r;
  logic        dvld_r;
  logic [2:0]  didx_r;

  logic [7:0]  ins_byte;
  logic [63:0] len_shift;
  logic [1:0]  grp;
  logic [31:0] f_val;
  logic [31:0] tmp;
  logic [31:0] sched_x;
  logic [31:0] sched_new;
  logic        out_take;

  // length bytes go out most significant first at positions 56..63
  assign len_shift = bits_r >> {~pos_r[2:0], 3'b000};

  always_comb begin
    unique case (cmd.bsel)
      sha1he_pkg::BSEL_IN:    ins_byte = in_data_byte;
      sha1he_pkg::BSEL_PAD80: ins_byte = sha1he_pkg::PAD_BYTE;
      sha1he_pkg::BSEL_ZERO:  ins_byte = 8'h00;
      sha1he_pkg::BSEL_LEN:   ins_byte = len_shift[7:0];
      default:                ins_byte = 8'h00;
    endcase
  end

  // round function
  always_comb begin
    priority if (rnd_r < 7'd20) begin
      grp = 2'd0;
    end else if (rnd_r < 7'd40) begin
      grp = 2'd1;
    end else if (rnd_r < 7'd60) begin
      grp = 2'd2;
    end else begin
      grp = 2'd3;
    end
    unique case (grp)
      2'd0:    f_val = (wk_r[1] & wk_r[2]) | (~wk_r[1] & wk_r[3]);
      2'd2:    f_val = (wk_r[1] & wk_r[2]) | (wk_r[1] & wk_r[3]) | (wk_r[2] & wk_r[3]);
      default: f_val = wk_r[1] ^ wk_r[2] ^ wk_r[3];
    endcase
  end

  assign tmp = {wk_r[0][26:0], wk_r[0][31:27]} + f_val + wk_r[4] + line_r[0]
             + sha1he_pkg::K_WORDS[grp];

  // window holds w[t..t+15], the word shifted in is w[t+16]
  assign sched_x   = line_r[13] ^ line_r[8] ^ line_r[2] ^ line_r[0];
  assign sched_new = {sched_x[30:0], sched_x[31]};

  assign out_take = dvld_r && !out_stall;

  // control and chaining state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) begin
        chain_r[i] <= sha1he_pkg::IV_WORDS[i];
      end
      pos_r  <= '0;
      bits_r <= '0;
      rnd_r  <= '0;
      dvld_r <= 1'b0;
      didx_r <= '0;
    end else begin
      unique case (cmd.op)
        sha1he_pkg::OP_INSERT: begin
          pos_r <= pos_r + 6'd1;
          if (cmd.count) begin
            bits_r <= bits_r + 64'd8;
          end
        end
        sha1he_pkg::OP_WINIT: begin
          rnd_r <= '0;
        end
        sha1he_pkg::OP_ROUND: begin
          rnd_r <= rnd_r + 7'd1;
        end
        sha1he_pkg::OP_CADD: begin
          for (int i = 0; i < NC; i++) begin
            chain_r[i] <= chain_r[i] + wk_r[i];
          end
        end
        sha1he_pkg::OP_FINAL: begin
          for (int i = 0; i < NC; i++) begin
            chain_r[i] <= sha1he_pkg::IV_WORDS[i];
          end
          bits_r <= '0;
        end
        default: begin
        end
      endcase
      if (cmd.op == sha1he_pkg::OP_FINAL) begin
        dvld_r <= 1'b1;
        didx_r <= '0;
      end else if (out_take) begin
        didx_r <= didx_r + 3'd1;
        if (didx_r == sha1he_pkg::LAST_IDX) begin
          dvld_r <= 1'b0;
        end
      end
    end
  end

  // payload: packing, schedule line, working words, digest buffer
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      sha1he_pkg::OP_INSERT: begin
        acc_r <= {acc_r[15:0], ins_byte};
        if (pos_r[1:0] == 2'd3) begin
          for (int i = 0; i < NS - 1; i++) begin
            line_r[i] <= line_r[i+1];
          end
          line_r[NS-1] <= {acc_r, ins_byte};
        end
      end
      sha1he_pkg::OP_WINIT: begin
        for (int i = 0; i < NC; i++) begin
          wk_r[i] <= chain_r[i];
        end
      end
      sha1he_pkg::OP_ROUND: begin
        for (int i = 0; i < NS - 1; i++) begin
          line_r[i] <= line_r[i+1];
        end
        line_r[NS-1] <= sched_new;
        wk_r[0] <= tmp;
        wk_r[1] <= wk_r[0];
        wk_r[2] <= {wk_r[1][1:0], wk_r[1][31:2]};
        wk_r[3] <= wk_r[2];
        wk_r[4] <= wk_r[3];
      end
      default: begin
      end
    endcase
    if (cmd.op == sha1he_pkg::OP_FINAL) begin
      for (int i = 0; i < NC; i++) begin
        dig_r[i] <= chain_r[i] + wk_r[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < NC - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
    end
  end

  assign stat.pos_end  = (pos_r == sha1he_pkg::END_POS);
  assign stat.pos_len  = (pos_r == sha1he_pkg::LEN_POS);
  assign stat.rnd_last = (rnd_r == 7'(sha1he_pkg::NUM_ROUNDS - 1));
  assign stat.out_busy = dvld_r;

  assign out_valid       = dvld_r;
  assign out_digest_word = dig_r[0];
  assign out_word_index  = didx_r;
  assign out_last_word   = (didx_r == sha1he_pkg::LAST_IDX);

endmodule

// ===== hw/rtl/sha1_hash_engine_top.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_engine_top
// sha-1 (160-bit digest) over a byte stream, one message byte per input word
// ----------------------------------------------------------------------------
// Usage: each input word carries one message byte (in_byte_valid high) or
// nothing, and in_last_item ends the message. Bytes are accepted one per
// cycle until 64 have been packed; the block then stalls for one load, 80
// rounds at one round per cycle through the single round unit, and one
// chaining add. On the last word the padding bytes and the eight length
// bytes go through the same byte path at one per cycle while no block is
// being compressed, followed by one or two compressions. The five digest
// words then leave from an output buffer, most significant word first, one
// per cycle while out_stall is low; the next message can stream in while
// they drain. Only the final hand-off into that buffer waits for it to
// empty. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sha1_hash_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last_item,
  // digest words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  // commands from the sequencer, status back from the datapath
  sha1he_pkg::cmd_t  cmd;
  sha1he_pkg::stat_t stat;

  // sequencer: owns the handshake on the input side and all step ordering
  sha1he_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte_valid (in_byte_valid),
    .in_last_item  (in_last_item),
    .in_stall      (in_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  // datapath: packing, schedule, round unit, chaining words, digest buffer
  sha1he_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

// ===== hw/rtl/sha1he_checker.sv =====
// ----------------------------------------------------------------------------
// sha1he_checker
// port-level checks on digest word ordering and end-of-message behavior
// ----------------------------------------------------------------------------
`include "sha1_hash_engine_top_assert.svh"

module sha1he_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_item,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // a digest always starts at word zero
  `SHA1HE_ASSERT_NOW(a_first_idx, $rose(out_valid), out_word_index == 3'd0, "digest start not at word zero")

  // words of a digest follow without gaps in the index
  `SHA1HE_ASSERT_NEXT(a_idx_step, out_valid && !out_stall && !out_last_word, out_valid && (out_word_index == $past(out_word_index) + 3'd1), "digest word index skipped")

  // a stalled digest word holds
  `SHA1HE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_digest_word) && $stable(out_word_index), "stalled digest word changed")

  // the end of a message always stalls the input for padding or compression work
  `SHA1HE_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && in_last_item, in_stall, "no padding after last word")

endmodule

bind sha1_hash_engine_top sha1he_checker u_chk (.*);
